// ----- rtl/core/mse_pkg.sv -----
// Package for the merge sort engine: sizes, cell control and status types.
// No dependencies; every other file of the engine imports it.
`default_nettype none

package mse_pkg;

  // Number of values one set may hold, and the width of a held value.
  localparam int unsigned MAX_ITEMS  = 64;
  localparam int unsigned DATA_WIDTH = 32;

  // Width of the external value fields.
  localparam int unsigned WORD_WIDTH = 32;

  // Fill counter must be able to hold MAX_ITEMS itself.
  localparam int unsigned CNT_WIDTH = $clog2(MAX_ITEMS + 1);

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_WIDTH-1:0]  cnt_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic  ins;    // insert din at its ordered place
    logic  shift;  // move every value one cell toward the head
    data_t din;    // value being inserted
  } mse_cell_ctl_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic  occ;    // cell holds a value
    logic  le;     // held value is less than or equal to din
    data_t val;    // held value
  } mse_cell_st_t;

endpackage

`default_nettype wire

// ----- rtl/core/mse_if.sv -----
// Valid/ready channel interfaces for the merge sort engine input and result.
// Depends on mse_pkg for the word width.
`default_nettype none

interface mse_in_if;
  import mse_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [WORD_WIDTH-1:0] value;
  logic                         last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface mse_out_if;
  import mse_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [WORD_WIDTH-1:0] sorted_value;
  logic                         last_out;
  logic                         overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input overflow,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/mse_cell.sv -----
// One cell of the sorting chain: holds a value and an occupied bit.
// Depends on mse_pkg for the control and status structs.
`default_nettype none

module mse_cell
  import mse_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mse_cell_ctl_t ctl,
  input  wire mse_cell_st_t  prev_st,  // neighbor toward the head
  input  wire mse_cell_st_t  next_st,  // neighbor toward the tail
  output mse_cell_st_t       st
);

  logic  occ_r, occ_nxt;
  data_t val_r, val_nxt;

  // Compare the held value against the broadcast value, as signed numbers.
  assign st.occ = occ_r;
  assign st.le  = occ_r && ($signed(val_r) <= $signed(ctl.din));
  assign st.val = val_r;

  // On insert, a cell that holds a value not above din keeps it. Otherwise it
  // takes din if its head neighbor stays put, or else takes that neighbor's
  // value. Equal values stay ahead of the new one, which keeps the sort stable.
  always_comb begin
    occ_nxt = occ_r;
    val_nxt = val_r;
    if (ctl.ins) begin
      if (!st.le) begin
        if (prev_st.le) begin
          occ_nxt = 1'b1;
          val_nxt = ctl.din;
        end else begin
          occ_nxt = prev_st.occ;
          val_nxt = prev_st.val;
        end
      end
    end else if (ctl.shift) begin
      occ_nxt = next_st.occ;
      val_nxt = next_st.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/merge_sort_engine_core.sv -----
// Top level of the merge sort engine: sequencer plus a chain of sort cells.
// Depends on mse_pkg, mse_if (mse_in_if, mse_out_if) and mse_cell.
//
//   Channel   Direction  Payload                                Handshake
//   in_word   sink       value[31:0], last_in                   valid/ready
//   out_word  source     sorted_value[31:0], last_out, overflow valid/ready
//
// Each accepted word is inserted into the ordered chain at its place. After the
// word marked last, the chain drains from its head, one word per cycle while
// out_word.ready is high; input is held off during the drain.
// Reset (rst_n, synchronous) empties the chain and clears the counters.
// A stall on the output simply holds the head cell and its flags.
`default_nettype none

module merge_sort_engine_core
  import mse_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  mse_in_if.sink      in_word,
  mse_out_if.source   out_word
);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  state_t        state_r;
  cnt_t          count_r;
  logic          drop_r;

  mse_cell_ctl_t cell_ctl;
  mse_cell_st_t  cell_st [MAX_ITEMS];
  logic          in_acc;
  logic          out_acc;
  logic          full;

  // Handshake decode.
  assign in_word.ready = (state_r == ST_LOAD);
  assign in_acc        = in_word.valid && (state_r == ST_LOAD);
  assign out_acc       = out_word.ready && (state_r == ST_DRAIN);
  assign full          = (count_r == cnt_t'(MAX_ITEMS));

  // Command to the chain.
  assign cell_ctl.ins   = in_acc && !full;
  assign cell_ctl.shift = out_acc;
  assign cell_ctl.din   = in_word.value[DATA_WIDTH-1:0];

  // The chain of cells, head at index 0.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    mse_cell_st_t prev_st;
    mse_cell_st_t next_st;

    if (i == 0) begin : g_head
      assign prev_st = '{occ: 1'b1, le: 1'b1, val: '0};
    end else begin : g_body
      assign prev_st = cell_st[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign next_st = '{occ: 1'b0, le: 1'b0, val: '0};
    end else begin : g_rest
      assign next_st = cell_st[i+1];
    end

    mse_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (cell_ctl),
      .prev_st (prev_st),
      .next_st (next_st),
      .st      (cell_st[i])
    );
  end

  // Result word comes straight from the head cell and the flags.
  assign out_word.valid        = (state_r == ST_DRAIN);
  assign out_word.sorted_value = WORD_WIDTH'($signed(cell_st[0].val));
  assign out_word.last_out     = (count_r == cnt_t'(1));
  assign out_word.overflow     = drop_r;

  // Sequencer: counts held words, tracks drops, switches load and drain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (full) begin
              drop_r <= 1'b1;
            end else begin
              count_r <= count_r + cnt_t'(1);
            end
            if (in_word.last_in) begin
              state_r <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (out_acc) begin
            if (count_r == cnt_t'(1)) begin
              count_r <= '0;
              drop_r  <= 1'b0;
              state_r <= ST_LOAD;
            end else begin
              count_r <= count_r - cnt_t'(1);
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- tb/merge_sort_engine_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking test of merge_sort_engine_core: marked sets go in, sorted words come out.
// Depends on mse_pkg and the mse_in_if / mse_out_if channel interfaces.

module merge_sort_engine_core_test;
  import mse_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_TARGET = 280;

  typedef logic signed [WORD_WIDTH-1:0] word_t;

  // One sorted word as the block should emit it.
  typedef struct {
    word_t value;
    logic  last;
    logic  overflow;
  } sorted_word_t;

  logic clk;
  logic rst_n;

  mse_in_if  in_word ();
  mse_out_if out_word ();

  merge_sort_engine_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word)
  );

  // Sorted words still owed by the block, oldest first.
  sorted_word_t pending_sorted[$];
  // Values of the set being loaded, kept in ascending order as they arrive.
  data_t        held_values[$];
  logic         held_dropped = 1'b0;

  int unsigned  words_sent = 0;
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  stall_left = 0;
  logic         src_steady = 1'b0;
  logic         sink_steady = 1'b0;

  // Free-running clock, 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Length of one idle stretch: mostly short, now and then long.
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 2);
    else if (roll < 92) return $urandom_range(3, 6);
    else return $urandom_range(12, 30);
  endfunction

  // Value mix: full random, small values that tie, extremes and values near them.
  function automatic word_t pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return word_t'($urandom());
    else if (roll < 70) return word_t'($signed($urandom_range(0, 8)) - 4);
    else if (roll < 80) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return '0;
        default: return '1;
      endcase
    end else if (roll < 90) return 32'sh8000_0000 + word_t'($urandom_range(0, 15));
    else return 32'sh7FFF_FFFF - word_t'($urandom_range(0, 15));
  endfunction

  // Track one accepted word. Each value goes behind every held value that is
  // not greater, so equal values keep arrival order. The word marked last
  // turns the held set into expected sorted words.
  task automatic take_word(input word_t word, input logic last);
    data_t        kept;
    int           pos;
    sorted_word_t expected;
    kept = word[DATA_WIDTH-1:0];
    if (held_values.size() < MAX_ITEMS) begin
      pos = held_values.size();
      while (pos > 0 && $signed(held_values[pos-1]) > $signed(kept)) pos--;
      held_values.insert(pos, kept);
    end else begin
      held_dropped = 1'b1;
    end
    if (last) begin
      foreach (held_values[k]) begin
        expected.value    = $signed(held_values[k]);
        expected.last     = (k == held_values.size() - 1);
        expected.overflow = held_dropped;
        pending_sorted.push_back(expected);
      end
      held_values.delete();
      held_dropped = 1'b0;
    end
  endtask

  // Offer one word after an optional gap and wait until the block takes it.
  // Valid stays high afterwards so back-to-back words follow without a gap.
  task automatic send_word(input word_t word, input logic last);
    int unsigned gap;
    gap = (!src_steady && $urandom_range(0, 2) == 0) ? idle_length() : 0;
    if (gap != 0) begin
      in_word.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word.valid   <= 1'b1;
    in_word.value   <= word;
    in_word.last_in <= last;
    do @(posedge clk); while (!in_word.ready);
    take_word(word, last);
    words_sent++;
  endtask

  task automatic send_set(input word_t words[$]);
    foreach (words[k]) send_word(words[k], k == words.size() - 1);
  endtask

  // Result side: random stalls on ready, with steady stretches in between.
  // Ready stays low while reset is held.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      out_word.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_word.ready <= 1'b0;
    end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
      stall_left <= idle_length() - 1;
      out_word.ready <= 1'b0;
    end else begin
      out_word.ready <= 1'b1;
    end
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk) begin
    sorted_word_t expected;
    if (rst_n && out_word.valid && out_word.ready) begin
      if (pending_sorted.size() == 0) begin
        $error("unexpected result word: sorted_value %0d", out_word.sorted_value);
        fail_count++;
      end else begin
        expected = pending_sorted.pop_front();
        if (out_word.sorted_value !== expected.value) begin
          $error("sorted_value: expected %0d, got %0d", expected.value,
                 out_word.sorted_value);
          fail_count++;
        end
        if (out_word.last_out !== expected.last) begin
          $error("last_out: expected %0b, got %0b", expected.last, out_word.last_out);
          fail_count++;
        end
        if (out_word.overflow !== expected.overflow) begin
          $error("overflow: expected %0b, got %0b", expected.overflow,
                 out_word.overflow);
          fail_count++;
        end
      end
    end
  end

  // Watchdog against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // A set of one word, at each end of the range.
  task automatic test_single_word();
    send_set('{32'sh8000_0000});
    send_set('{32'sh7FFF_FFFF});
  endtask

  task automatic test_extremes();
    send_set('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sd1, 32'sd1, 32'sh7FFF_FFFF});
  endtask

  // Repeated values must come out grouped and in order.
  task automatic test_ties();
    send_set('{32'sd5, -32'sd3, 32'sd5, 32'sd5, -32'sd3, 32'sd0, 32'sd5});
  endtask

  task automatic test_descending();
    send_set('{32'sd900, 32'sd70, 32'sd6, -32'sd6, -32'sd70, -32'sd900});
  endtask

  // Exactly as many words as the block holds, with no idling on either side.
  task automatic test_full_set();
    word_t words[$];
    repeat (MAX_ITEMS) words.push_back(pick_value());
    src_steady  = 1'b1;
    sink_steady = 1'b1;
    send_set(words);
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  // Two words beyond capacity; the dropped final word still closes the set.
  task automatic test_overflow();
    word_t words[$];
    repeat (MAX_ITEMS + 2) words.push_back(pick_value());
    send_set(words);
  endtask

  // Small random sets until the word budget is spent.
  task automatic test_random_sets();
    word_t       words[$];
    int unsigned set_size;
    while (words_sent < RANDOM_TARGET) begin
      words.delete();
      set_size = $urandom_range(1, 12);
      repeat (set_size) words.push_back(pick_value());
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      send_set(words);
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_word.valid   <= 1'b0;
    in_word.value   <= '0;
    in_word.last_in <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_word();
    test_extremes();
    test_ties();
    test_descending();
    test_full_set();
    test_overflow();
    test_random_sets();

    // Stop offering words, let the last set drain, then watch a while longer.
    @(posedge clk);
    in_word.valid <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && pending_sorted.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
